@@ hw/rtl/rdm_pkg.sv @@
// Shared types, codes and constants of the random depth-first maze generator.
`default_nettype none

package rdm_pkg;

  localparam int GRID_SIDE_DEF   = 16;
  localparam int STACK_DEPTH_DEF = 256;

  localparam logic [15:0] LFSR_TAPS   = 16'hB400;
  localparam logic [15:0] SEED_RESET  = 16'd44257;
  localparam logic [8:0]  REACHED_MAX = 9'd511;

  // Command codes.
  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_READ     = 1'b1;

  // Walk directions, tried cyclically from the drawn one. North is one row up.
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // Configuration register index (paddr[2]).
  localparam logic REG_RANDOM_SEED = 1'b0;

  typedef struct packed {
    logic       operation;
    logic [3:0] row;
    logic [3:0] col;
  } cmd_t;

  typedef struct packed {
    logic       top_closed;
    logic       left_closed;
    logic       was_visited;
    logic [8:0] cells_reached;
  } res_t;

  typedef struct packed {
    logic visited;
    logic left_closed;
    logic top_closed;
  } cell_t;

  localparam cell_t CELL_RESET = '{visited: 1'b0, left_closed: 1'b1, top_closed: 1'b1};

  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    lfsr_next = {1'b0, s[15:1]} ^ (s[0] ? LFSR_TAPS : 16'h0000);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/random_dfs_maze_generator.sv @@
// Top level of the random depth-first maze generator: register port, walk and memories.
//
//   channel   handshake             payload          notes
//   command   start & !busy         cmd (cmd_t)      operation, row, col
//   result    done (one cycle)      result (res_t)   cannot be held off
//   config    psel&penable&pwrite   pwdata[15:0]     random_seed at byte address 0
//
// A read passes through S_RDWAIT before its result is shown; one off the grid is answered from idle.
// A generate first sweeps the cell store, one entry a cycle, then walks: each step passes
// through S_STEP and S_CUR, then S_CHECK for every neighbor probed (S_PROBE between probes),
// then S_WCUR, and S_POP for a pop or S_WNEXT for a move right or down, bounded by the single
// cell store port; a full 16x16 walk is 511 steps.
// After reset the same clearing pass runs and busy stays high until it ends.
// The block takes one item at a time; busy is high until the item's result is shown.
`default_nettype none

module random_dfs_maze_generator #(
  parameter int GRID_SIDE   = rdm_pkg::GRID_SIDE_DEF,
  parameter int STACK_DEPTH = rdm_pkg::STACK_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire rdm_pkg::cmd_t cmd,
  output logic               busy,
  output logic               done,
  output rdm_pkg::res_t      result,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready
);

  localparam int CW  = $clog2(GRID_SIDE);
  localparam int AW  = 2 * CW;
  localparam int SIW = $clog2(STACK_DEPTH);

  logic [15:0]    random_seed;
  logic           cell_we;
  logic [AW-1:0]  cell_addr;
  rdm_pkg::cell_t cell_wdata;
  rdm_pkg::cell_t cell_rdata;
  logic           stk_we;
  logic [SIW-1:0] stk_addr;
  logic [AW-1:0]  stk_wdata;
  logic [AW-1:0]  stk_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rdm_pkg::REG_RANDOM_SEED) ? {16'h0000, random_seed} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      random_seed <= rdm_pkg::SEED_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == rdm_pkg::REG_RANDOM_SEED) begin
      random_seed <= pwdata[15:0];
    end
  end

  rdm_ctrl #(
    .GRID_SIDE   (GRID_SIDE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .seed       (random_seed),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .cell_we    (cell_we),
    .cell_addr  (cell_addr),
    .cell_wdata (cell_wdata),
    .cell_rdata (cell_rdata),
    .stk_we     (stk_we),
    .stk_addr   (stk_addr),
    .stk_wdata  (stk_wdata),
    .stk_rdata  (stk_rdata)
  );

  rdm_cell_mem #(
    .AW (AW)
  ) u_cell_mem (
    .clk   (clk),
    .we    (cell_we),
    .addr  (cell_addr),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  rdm_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (SIW),
    .DW    (AW)
  ) u_stack_mem (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

`ifndef SYNTH
  // A result is only shown once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // An accepted read either answers at once or keeps the block busy.
  a_read_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.operation == rdm_pkg::OP_READ) |=> (busy || done))
    else $error("read item dropped");

  // The block only becomes busy because an item was offered.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without an accepted item");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/rdm_cell_mem.sv @@
// Cell store: walls and visited mark of every grid cell, one read-modify-write port.
`default_nettype none

module rdm_cell_mem #(
  parameter int AW = 8
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  addr,
  input  wire rdm_pkg::cell_t wdata,
  output rdm_pkg::cell_t      rdata
);

  rdm_pkg::cell_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rdm_stack_mem.sv @@
// Path stack: cell positions pushed by the walk, one port.
`default_nettype none

module rdm_stack_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/rdm_ctrl.sv @@
// Walk sequencer and read path: clearing pass, neighbor probes, wall opening, push, pop and cell reads.
`default_nettype none

module rdm_ctrl #(
  parameter int GRID_SIDE   = rdm_pkg::GRID_SIDE_DEF,
  parameter int STACK_DEPTH = rdm_pkg::STACK_DEPTH_DEF,
  localparam int CW  = $clog2(GRID_SIDE),
  localparam int AW  = 2 * CW,
  localparam int SIW = $clog2(STACK_DEPTH),
  localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire rdm_pkg::cmd_t  cmd,
  input  wire logic [15:0]    seed,
  output logic                busy,
  output logic                done,
  output rdm_pkg::res_t       result,
  output logic                cell_we,
  output logic     [AW-1:0]   cell_addr,
  output rdm_pkg::cell_t      cell_wdata,
  input  wire rdm_pkg::cell_t cell_rdata,
  output logic                stk_we,
  output logic     [SIW-1:0]  stk_addr,
  output logic     [AW-1:0]   stk_wdata,
  input  wire logic [AW-1:0]  stk_rdata
);

  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_STEP, S_CUR, S_PROBE, S_CHECK, S_WCUR, S_WNEXT, S_POP, S_RDWAIT
  } state_t;

  state_t          state;
  logic [AW-1:0]   clr_addr;
  logic            walk_go;
  logic            reply;
  logic [AW-1:0]   walk_pos;
  logic [AW-1:0]   next_pos;
  logic [SPW-1:0]  stack_top;
  logic [15:0]     lfsr;
  logic [1:0]      first_dir;
  logic [1:0]      k;
  logic [1:0]      probe_dir;
  logic            found;
  rdm_pkg::cell_t  cur_cell;
  rdm_pkg::cell_t  nxt_cell;
  logic [8:0]      reached;

  logic [CW-1:0]   walk_r;
  logic [CW-1:0]   walk_c;
  logic [AW-1:0]   start_pos;
  logic            start_in;
  logic [15:0]     lfsr_adv;
  logic [3:0]      dir_ok;
  logic            cand_any;
  logic [1:0]      cand_j;
  logic [1:0]      cand_dir;
  logic [AW-1:0]   nb_pos;
  logic            push;
  rdm_pkg::cell_t  cur_wr;
  rdm_pkg::cell_t  nxt_wr;
  logic [8:0]      reached_inc;
  logic [SPW-1:0]  stack_dec;

  assign walk_r    = walk_pos[AW-1:CW];
  assign walk_c    = walk_pos[CW-1:0];
  assign start_pos = {CW'(cmd.row), CW'(cmd.col)};
  assign start_in  = (32'(cmd.row) < GRID_SIDE) && (32'(cmd.col) < GRID_SIDE);
  assign lfsr_adv  = rdm_pkg::lfsr_next(lfsr);
  assign busy      = (state != S_IDLE);

  always_comb begin
    dir_ok = '0;
    dir_ok[rdm_pkg::DIR_NORTH] = (walk_r != '0);
    dir_ok[rdm_pkg::DIR_EAST]  = (walk_c != LAST);
    dir_ok[rdm_pkg::DIR_SOUTH] = (walk_r != LAST);
    dir_ok[rdm_pkg::DIR_WEST]  = (walk_c != '0);
  end

  // First direction at or after probe slot k that stays inside the grid.
  always_comb begin
    logic [1:0] dj;
    cand_any = 1'b0;
    cand_j   = k;
    cand_dir = first_dir;
    for (int j = 3; j >= 0; j--) begin
      dj = first_dir + 2'(j);
      if ((2'(j) >= k) && dir_ok[dj]) begin
        cand_any = 1'b1;
        cand_j   = 2'(j);
        cand_dir = dj;
      end
    end
  end

  always_comb begin
    case (cand_dir)
      rdm_pkg::DIR_NORTH: nb_pos = {walk_r - CW'(1), walk_c};
      rdm_pkg::DIR_EAST:  nb_pos = {walk_r, walk_c + CW'(1)};
      rdm_pkg::DIR_SOUTH: nb_pos = {walk_r + CW'(1), walk_c};
      default:            nb_pos = {walk_r, walk_c - CW'(1)};
    endcase
  end

  assign push      = found && (stack_top < SPW'(STACK_DEPTH));
  assign stack_dec = stack_top - SPW'(1);

  always_comb begin
    cur_wr             = cur_cell;
    cur_wr.visited     = 1'b1;
    cur_wr.top_closed  = cur_cell.top_closed && !(push && probe_dir == rdm_pkg::DIR_NORTH);
    cur_wr.left_closed = cur_cell.left_closed && !(push && probe_dir == rdm_pkg::DIR_WEST);
    nxt_wr             = nxt_cell;
    nxt_wr.top_closed  = nxt_cell.top_closed && (probe_dir != rdm_pkg::DIR_SOUTH);
    nxt_wr.left_closed = nxt_cell.left_closed && (probe_dir != rdm_pkg::DIR_EAST);
    if (!cur_cell.visited && reached != rdm_pkg::REACHED_MAX) begin
      reached_inc = reached + 9'd1;
    end else begin
      reached_inc = reached;
    end
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_addr  = walk_pos;
    cell_wdata = cur_wr;
    stk_we     = 1'b0;
    stk_addr   = stack_top[SIW-1:0];
    stk_wdata  = walk_pos;
    case (state)
      S_IDLE: begin
        cell_addr = start_pos;
      end
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_addr  = clr_addr;
        cell_wdata = rdm_pkg::CELL_RESET;
      end
      S_CUR, S_PROBE: begin
        cell_addr = nb_pos;
      end
      S_WCUR: begin
        cell_we = 1'b1;
        stk_we  = push;
        if (!push) begin
          stk_addr = stack_dec[SIW-1:0];
        end
      end
      S_WNEXT: begin
        cell_we    = 1'b1;
        cell_addr  = next_pos;
        cell_wdata = nxt_wr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      walk_go   <= 1'b0;
      reply     <= 1'b0;
      done      <= 1'b0;
      stack_top <= '0;
      lfsr      <= rdm_pkg::SEED_RESET;
      walk_pos  <= '0;
      reached   <= '0;
      found     <= 1'b0;
      k         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd.operation == rdm_pkg::OP_GENERATE) begin
              lfsr      <= seed;
              stack_top <= '0;
              reached   <= '0;
              walk_pos  <= start_pos;
              walk_go   <= start_in;
              reply     <= 1'b1;
              clr_addr  <= '0;
              state     <= S_CLEAR;
            end else if (start_in) begin
              state <= S_RDWAIT;
            end else begin
              done   <= 1'b1;
              result <= '0;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            if (walk_go) begin
              state <= S_STEP;
            end else begin
              state <= S_IDLE;
              if (reply) begin
                done   <= 1'b1;
                result <= '0;
              end
            end
          end
        end
        S_STEP: begin
          lfsr      <= lfsr_adv;
          first_dir <= lfsr_adv[1:0];
          k         <= '0;
          state     <= S_CUR;
        end
        S_CUR, S_PROBE: begin
          if (state == S_CUR) begin
            cur_cell <= cell_rdata;
          end
          if (cand_any) begin
            k         <= cand_j;
            probe_dir <= cand_dir;
            next_pos  <= nb_pos;
            state     <= S_CHECK;
          end else begin
            found <= 1'b0;
            state <= S_WCUR;
          end
        end
        S_CHECK: begin
          if (!cell_rdata.visited) begin
            found    <= 1'b1;
            nxt_cell <= cell_rdata;
            state    <= S_WCUR;
          end else if (k == 2'd3) begin
            found <= 1'b0;
            state <= S_WCUR;
          end else begin
            k     <= k + 2'd1;
            state <= S_PROBE;
          end
        end
        S_WCUR: begin
          reached <= reached_inc;
          if (push) begin
            stack_top <= stack_top + SPW'(1);
            if (probe_dir == rdm_pkg::DIR_EAST || probe_dir == rdm_pkg::DIR_SOUTH) begin
              state <= S_WNEXT;
            end else begin
              walk_pos <= next_pos;
              state    <= S_STEP;
            end
          end else if (stack_top != '0) begin
            stack_top <= stack_dec;
            state     <= S_POP;
          end else begin
            done   <= 1'b1;
            result <= '{top_closed: 1'b0, left_closed: 1'b0, was_visited: 1'b0,
                        cells_reached: reached_inc};
            state  <= S_IDLE;
          end
        end
        S_WNEXT: begin
          walk_pos <= next_pos;
          state    <= S_STEP;
        end
        S_POP: begin
          walk_pos <= stk_rdata;
          state    <= S_STEP;
        end
        S_RDWAIT: begin
          done                 <= 1'b1;
          result.top_closed    <= cell_rdata.top_closed;
          result.left_closed   <= cell_rdata.left_closed;
          result.was_visited   <= cell_rdata.visited;
          result.cells_reached <= '0;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the random depth-first maze generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID  = rdm_pkg::GRID_SIDE_DEF;
  localparam int STACK = rdm_pkg::STACK_DEPTH_DEF;
  localparam int CELLS = GRID * GRID;

  localparam logic [2:0] SEED_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  localparam int ITEM_TARGET = 290;

  class maze_scoreboard;
    rdm_pkg::cell_t maze [CELLS];
    logic [15:0]    seed;
    rdm_pkg::res_t  pending [$];
    int             errors;

    function new();
      foreach (maze[i]) maze[i] = rdm_pkg::CELL_RESET;
      seed = rdm_pkg::SEED_RESET;
      errors = 0;
    endfunction

    // Rebuilds the whole maze the way the block walks it and returns the visit count.
    function logic [8:0] carve_maze(int r0, int c0);
      logic [7:0]  trail [STACK];
      logic [15:0] lfsr;
      logic [8:0]  reached;
      logic [1:0]  dir;
      logic [1:0]  way;
      bit          open_found;
      bit          walking;
      int          depth, pos, nxt, cr, cc, nr, nc, k;
      foreach (maze[i]) maze[i] = rdm_pkg::CELL_RESET;
      lfsr = seed;
      depth = 0;
      reached = '0;
      way = rdm_pkg::DIR_NORTH;
      walking = (r0 < GRID) && (c0 < GRID);
      pos = r0 * GRID + c0;
      while (walking) begin
        cr = pos / GRID;
        cc = pos % GRID;
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ rdm_pkg::LFSR_TAPS) : (lfsr >> 1);
        dir = lfsr[1:0];
        open_found = 1'b0;
        nxt = 0;
        for (k = 0; k < 4 && !open_found; k++) begin
          nr = cr;
          nc = cc;
          case (dir)
            rdm_pkg::DIR_NORTH: nr = cr - 1;
            rdm_pkg::DIR_EAST:  nc = cc + 1;
            rdm_pkg::DIR_SOUTH: nr = cr + 1;
            rdm_pkg::DIR_WEST:  nc = cc - 1;
          endcase
          if (nr >= 0 && nc >= 0 && nr < GRID && nc < GRID &&
              !maze[nr * GRID + nc].visited) begin
            open_found = 1'b1;
            way = dir;
            nxt = nr * GRID + nc;
          end
          dir = dir + 2'd1;
        end
        if (!maze[pos].visited) begin
          maze[pos].visited = 1'b1;
          if (reached != rdm_pkg::REACHED_MAX) reached++;
        end
        // A full stack turns an open neighbor into a dead end.
        if (open_found && depth < STACK) begin
          trail[depth] = pos[7:0];
          depth++;
          case (way)
            rdm_pkg::DIR_NORTH: maze[pos].top_closed  = 1'b0;
            rdm_pkg::DIR_EAST:  maze[nxt].left_closed = 1'b0;
            rdm_pkg::DIR_SOUTH: maze[nxt].top_closed  = 1'b0;
            rdm_pkg::DIR_WEST:  maze[pos].left_closed = 1'b0;
          endcase
          pos = nxt;
        end else if (depth > 0) begin
          depth--;
          pos = trail[depth];
        end else begin
          walking = 1'b0;
        end
      end
      return reached;
    endfunction

    function void note_cmd(rdm_pkg::cmd_t c);
      rdm_pkg::res_t  want;
      rdm_pkg::cell_t spot;
      want = '0;
      if (c.operation == rdm_pkg::OP_GENERATE) begin
        want.cells_reached = carve_maze(c.row, c.col);
      end else if (c.row < GRID && c.col < GRID) begin
        spot = maze[c.row * GRID + c.col];
        want.top_closed  = spot.top_closed;
        want.left_closed = spot.left_closed;
        want.was_visited = spot.visited;
      end
      pending = {pending, want};
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rdm_pkg::res_t got);
      rdm_pkg::res_t want;
      if (pending.size() == 0) begin
        $display("%0t: result %h arrived with no item outstanding", $time, got);
        errors++;
      end else begin
        want = pending.pop_front();
        field_check("top_closed", want.top_closed, got.top_closed);
        field_check("left_closed", want.left_closed, got.left_closed);
        field_check("was_visited", want.was_visited, got.was_visited);
        field_check("cells_reached", want.cells_reached, got.cells_reached);
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          start;
  rdm_pkg::cmd_t cmd;
  logic          busy;
  logic          done;
  rdm_pkg::res_t result;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  maze_scoreboard sb = new();
  int sent = 0;
  int burst_left = 0;

  random_dfs_maze_generator u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic rdm_pkg::cmd_t cell_cmd(logic op, int r, int c);
    rdm_pkg::cmd_t x;
    x.operation = op;
    x.row = r[3:0];
    x.col = c[3:0];
    return x;
  endfunction

  // Presents one item, waits for it to be taken, then either keeps start up for the
  // next item of the burst or opens a gap of random length.
  task automatic issue(rdm_pkg::cmd_t c);
    int gap;
    @(negedge clk);
    cmd <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cmd(c);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Holds off new items until the block is idle and every result is in.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == rdm_pkg::REG_RANDOM_SEED) sb.seed = data[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    #(40_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [31:0] data;
    int          n, reads;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settle();

    // Cells as left by reset, then a walk with the reset seed from a corner.
    issue(cell_cmd(rdm_pkg::OP_READ, 0, 0));
    issue(cell_cmd(rdm_pkg::OP_READ, 15, 15));
    issue(cell_cmd(rdm_pkg::OP_GENERATE, 0, 0));
    issue(cell_cmd(rdm_pkg::OP_READ, 0, 0));
    issue(cell_cmd(rdm_pkg::OP_READ, 15, 15));
    issue(cell_cmd(rdm_pkg::OP_READ, 0, 15));
    issue(cell_cmd(rdm_pkg::OP_READ, 15, 0));
    issue(cell_cmd(rdm_pkg::OP_READ, 7, 8));

    // Largest seed; a write to the unused register must change nothing.
    settle();
    reg_write(SEED_ADDR, 32'h0000FFFF);
    reg_write(SPARE_ADDR, 32'h00001234);
    issue(cell_cmd(rdm_pkg::OP_GENERATE, 15, 15));
    issue(cell_cmd(rdm_pkg::OP_READ, 5, 10));
    issue(cell_cmd(rdm_pkg::OP_READ, 15, 15));
    issue(cell_cmd(rdm_pkg::OP_READ, 0, 0));

    settle();
    reg_write(SEED_ADDR, 32'd1);
    issue(cell_cmd(rdm_pkg::OP_GENERATE, 15, 0));
    issue(cell_cmd(rdm_pkg::OP_READ, 0, 15));
    issue(cell_cmd(rdm_pkg::OP_READ, 9, 4));

    // A zero seed keeps the LFSR at zero, so every step tries up first.
    settle();
    reg_write(SEED_ADDR, 32'd0);
    issue(cell_cmd(rdm_pkg::OP_GENERATE, 0, 15));
    issue(cell_cmd(rdm_pkg::OP_READ, 0, 0));
    issue(cell_cmd(rdm_pkg::OP_READ, 8, 3));

    // Only the low half of the write data reaches the seed.
    settle();
    reg_write(SEED_ADDR, 32'hFFFF5A3C);
    issue(cell_cmd(rdm_pkg::OP_GENERATE, 7, 7));
    issue(cell_cmd(rdm_pkg::OP_READ, 7, 7));

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 7))
          0:       data = 32'd0;
          1:       data = 32'd1;
          2:       data = 32'h0000FFFF;
          default: data = $urandom;
        endcase
        reg_write(($urandom_range(0, 4) == 0) ? SPARE_ADDR : SEED_ADDR, data);
      end
      if ($urandom_range(0, 9) == 0) begin
        // Loose mix: back-to-back walks and reads of a stale maze.
        repeat ($urandom_range(1, 4)) begin
          issue(cell_cmd(($urandom_range(0, 2) == 0) ? rdm_pkg::OP_GENERATE : rdm_pkg::OP_READ,
                         $urandom_range(0, 15), $urandom_range(0, 15)));
        end
      end else begin
        issue(cell_cmd(rdm_pkg::OP_GENERATE, $urandom_range(0, 15), $urandom_range(0, 15)));
        reads = $urandom_range(4, 14);
        repeat (reads) begin
          issue(cell_cmd(rdm_pkg::OP_READ, $urandom_range(0, 15), $urandom_range(0, 15)));
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    for (n = 0; n < 20000 && sb.pending.size() != 0; n++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
